FILE: rtl/core/uer_pkg.sv
package uer_pkg;

  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned TrigW      = 10;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned PeriodW    = 20;
  localparam int unsigned DistW      = 19;
  localparam int unsigned ProdW      = 25;
  localparam int unsigned DistShift  = 6;

  localparam logic [ProdW-1:0] DistScale = 25'd281;

  localparam logic [CfgIndexW-1:0] RegTriggerTicks  = 3'd0;
  localparam logic [CfgIndexW-1:0] RegEchoTimeout   = 3'd1;
  localparam logic [CfgIndexW-1:0] RegPeriodTicks   = 3'd2;
  localparam logic [CfgIndexW-1:0] RegFailsafeLimit = 3'd3;
  localparam logic [CfgIndexW-1:0] RegPublishLimit  = 3'd4;

  typedef struct packed {
    logic echo_level;
    logic stop_request;
  } in_item_t;

  typedef struct packed {
    logic             trigger_out;
    logic             measure_done;
    logic             timed_out;
    logic [DistW-1:0] distance_q8;
    logic             publish;
    logic             failsafe;
  } out_item_t;

  typedef struct packed {
    logic [TrigW-1:0]    trigger_ticks;
    logic [TimeoutW-1:0] echo_timeout_ticks;
    logic [PeriodW-1:0]  period_ticks;
    logic [DistW-1:0]    failsafe_limit_q8;
    logic [DistW-1:0]    publish_limit_q8;
  } cfg_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_t;

endpackage

FILE: rtl/core/uer_cfg_regs.sv
module uer_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [uer_pkg::CfgDataW-1:0]  cfg_wdata,
  output uer_pkg::cfg_t                 cfg
);

  uer_pkg::cfg_t cfg_r;
  uer_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::RegTriggerTicks:
          cfg_nxt.trigger_ticks = cfg_wdata[uer_pkg::TrigW-1:0];
        uer_pkg::RegEchoTimeout:
          cfg_nxt.echo_timeout_ticks = cfg_wdata[uer_pkg::TimeoutW-1:0];
        uer_pkg::RegPeriodTicks:
          cfg_nxt.period_ticks = cfg_wdata[uer_pkg::PeriodW-1:0];
        uer_pkg::RegFailsafeLimit:
          cfg_nxt.failsafe_limit_q8 = cfg_wdata[uer_pkg::DistW-1:0];
        uer_pkg::RegPublishLimit:
          cfg_nxt.publish_limit_q8 = cfg_wdata[uer_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks      <= 10'd10;
      cfg_r.echo_timeout_ticks <= 16'd30000;
      cfg_r.period_ticks       <= 20'd33333;
      cfg_r.failsafe_limit_q8  <= 19'd128000;
      cfg_r.publish_limit_q8   <= 19'd25600;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/uer_core.sv
module uer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  uer_pkg::in_item_t  item,
  input  uer_pkg::cfg_t      cfg,
  output uer_pkg::out_item_t result
);

  uer_pkg::phase_t                phase_r, phase_nxt;
  logic [uer_pkg::PeriodW-1:0]    period_count_r, period_count_nxt;
  logic [uer_pkg::TimeoutW-1:0]   phase_count_r, phase_count_nxt;
  logic                           start_pending_r, start_pending_nxt;
  logic [uer_pkg::DistW-1:0]      last_distance_r, last_distance_nxt;
  logic                           failsafe_r, failsafe_nxt;

  logic [uer_pkg::PeriodW-1:0]    per_m1;
  logic [uer_pkg::TrigW-1:0]      trig_len;
  logic                           wrap;
  logic                           pending_a;
  logic                           start;
  uer_pkg::phase_t                ph;
  logic [uer_pkg::TimeoutW-1:0]   cnt;
  logic [uer_pkg::ProdW-1:0]      prod;
  logic [uer_pkg::DistW-1:0]      dist_q8;
  logic                           trig_out, done, tout, pub;

  assign per_m1   = (cfg.period_ticks == '0) ? '0 : cfg.period_ticks - 1'b1;
  assign trig_len = (cfg.trigger_ticks == '0) ? uer_pkg::TrigW'(1) : cfg.trigger_ticks;
  assign wrap      = (period_count_r >= per_m1);
  assign pending_a = wrap | start_pending_r;
  assign start     = (phase_r == uer_pkg::PH_IDLE) && pending_a && !item.stop_request;
  assign ph        = start ? uer_pkg::PH_TRIG : phase_r;
  assign cnt       = start ? '0 : phase_count_r;

  // pulse width to 1/256 cm; 16-bit width never exceeds the 19-bit range
  assign prod = {{(uer_pkg::ProdW-uer_pkg::TimeoutW){1'b0}}, phase_count_r} * uer_pkg::DistScale;
  assign dist_q8 = prod[uer_pkg::DistShift +: uer_pkg::DistW];

  always_comb begin
    period_count_nxt  = wrap ? '0 : period_count_r + 1'b1;
    start_pending_nxt = start ? 1'b0 : pending_a;
    phase_nxt         = ph;
    phase_count_nxt   = cnt;
    last_distance_nxt = last_distance_r;
    failsafe_nxt      = failsafe_r;
    trig_out          = 1'b0;
    done              = 1'b0;
    tout              = 1'b0;
    pub               = 1'b0;
    unique case (ph)
      uer_pkg::PH_IDLE: ;
      uer_pkg::PH_TRIG: begin
        trig_out        = 1'b1;
        phase_count_nxt = cnt + 1'b1;
        if (phase_count_nxt >= {{(uer_pkg::TimeoutW-uer_pkg::TrigW){1'b0}}, trig_len}) begin
          phase_nxt       = uer_pkg::PH_RISE;
          phase_count_nxt = '0;
        end
      end
      uer_pkg::PH_RISE: begin
        if (item.echo_level) begin
          phase_nxt       = uer_pkg::PH_HIGH;
          phase_count_nxt = uer_pkg::TimeoutW'(1);
        end else if (cnt >= cfg.echo_timeout_ticks) begin
          done = 1'b1;
          tout = 1'b1;
        end else begin
          phase_count_nxt = cnt + 1'b1;
        end
      end
      uer_pkg::PH_HIGH: begin
        if (!item.echo_level) begin
          last_distance_nxt = dist_q8;
          if (dist_q8 > cfg.failsafe_limit_q8) failsafe_nxt = 1'b1;
          pub  = (dist_q8 <= cfg.publish_limit_q8);
          done = 1'b1;
        end else if (cnt >= cfg.echo_timeout_ticks) begin
          done = 1'b1;
          tout = 1'b1;
        end else begin
          phase_count_nxt = cnt + 1'b1;
        end
      end
      default: ;
    endcase
    if (done) begin
      if (tout) failsafe_nxt = 1'b1;
      phase_nxt       = uer_pkg::PH_IDLE;
      phase_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= uer_pkg::PH_IDLE;
      period_count_r  <= '0;
      phase_count_r   <= '0;
      start_pending_r <= 1'b1;
      last_distance_r <= '0;
      failsafe_r      <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      period_count_r  <= period_count_nxt;
      phase_count_r   <= phase_count_nxt;
      start_pending_r <= start_pending_nxt;
      last_distance_r <= last_distance_nxt;
      failsafe_r      <= failsafe_nxt;
    end
  end

  always_comb begin
    result.trigger_out  = trig_out;
    result.measure_done = done;
    result.timed_out    = tout;
    result.distance_q8  = last_distance_nxt;
    result.publish      = pub;
    result.failsafe     = failsafe_nxt;
  end

endmodule

FILE: rtl/core/uer_out_queue.sv
module uer_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  uer_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output uer_pkg::out_item_t out_data
);

  uer_pkg::out_item_t mem [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/ultrasonic_echo_ranger_top.sv
// input beats are registered, then stepped into the result queue, which sets out_valid
// one beat per cycle if the queue has room; the tick step is a single registered pass
// a two-entry result queue lets input beats keep flowing while a result waits
// reset (rst_n low, synchronous): idle, counters zero, start pending, flags clear
// configuration returns to its default values on reset
module ultrasonic_echo_ranger_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  uer_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output uer_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [uer_pkg::CfgDataW-1:0]  cfg_wdata
);

  logic               in_valid_r, in_valid_nxt;
  uer_pkg::in_item_t  in_item_r;
  logic               q_full;
  logic               advance;
  logic               accept;
  uer_pkg::cfg_t      cfg;
  uer_pkg::out_item_t result;

  assign advance  = in_valid_r && !q_full;
  assign in_stall = in_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign in_valid_nxt = accept || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_item_r <= in_data;
  end

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  uer_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_data (result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/uer_checker.sv
module uer_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input uer_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result beat changed");

  a_tout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timed_out |-> out_data.measure_done && out_data.failsafe)
    else $error("timeout without finished measurement or failsafe");

  a_pub_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.publish |->
      out_data.measure_done && !out_data.timed_out && !out_data.trigger_out)
    else $error("publish on a beat that is not a good reading");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (.*);
